FILE: rtl/bcr_pkg.sv
// Shared constants, types and handshake structs for the bypass crossfade ramp.
package bcr_pkg;

   localparam int unsigned SampleW = 24;
   localparam int unsigned RampW = 16;
   localparam int unsigned MixW = 17;
   localparam int unsigned IoCh = 2;
   localparam int unsigned ChannelsDefault = 2;
   localparam int unsigned DivSteps = 17;
   localparam int unsigned DivCntW = $clog2(DivSteps);
   localparam logic [RampW-1:0] RampReset = 16'd480;

   typedef logic signed [SampleW-1:0] sample_type;

   typedef struct packed {
      logic             start;
      logic [RampW-1:0] completed;
      logic [RampW-1:0] total;
   } div_req_type;

   typedef struct packed {
      logic            done;
      logic [MixW-1:0] mix;
   } div_rsp_type;

   typedef struct packed {
      logic            go;
      sample_type      src;
      sample_type      dst;
      logic [MixW-1:0] mix;
   } lerp_req_type;

   typedef struct packed {
      logic       valid;
      sample_type result;
   } lerp_rsp_type;

endpackage

FILE: rtl/bypass_crossfade_ramp.sv
// Top level: stereo bypass switch with a linear crossfade ramp.
//
//   group   dir  tdata (low bit up)                         tuser       tlast
//   req_    in   wet_left, wet_right, dry_left, dry_right   processed   end_of_block
//   rsp_    out  out_left, out_right                        fading      -
//   csr_    in   wr_data = ramp_frames                      -           -
//
// A frame outside a crossfade goes from accept straight to the output register.
// A faded frame runs 17 divider steps and picks up the mix; then, per channel, it
// issues once into the shared multiply pipeline and waits for the result; last, it
// loads the output register.
// req_tready is low while a frame is in work; a stalled result waits in the
// output register while the next frame is accepted. Synchronous reset.
module bypass_crossfade_ramp
   import bcr_pkg::*;
#(
   parameter int unsigned CHANNELS = ChannelsDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [4*SampleW-1:0]     req_tdata,   // wet_left, wet_right, dry_left, dry_right
   input  logic                     req_tuser,   // processed
   input  logic                     req_tlast,   // end_of_block
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [2*SampleW-1:0]     rsp_tdata,   // out_left, out_right
   output logic                     rsp_tuser,   // fading
   input  logic                     csr_wr_en,
   input  logic [RampW-1:0]         csr_wr_data
);

   localparam int unsigned NumLanes = (CHANNELS < IoCh) ? CHANNELS : IoCh;
   localparam int unsigned LaneW = (IoCh > 1) ? $clog2(IoCh) : 1;
   localparam logic [LaneW-1:0] LastLane = LaneW'(NumLanes - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIV    = 3'd1;
   localparam logic [2:0] ST_ISSUE  = 3'd2;
   localparam logic [2:0] ST_WAIT   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [RampW-1:0]   ramp_ff;
   sample_type         start_ff [IoCh];
   sample_type         start_in [IoCh];
   sample_type         held_ff [IoCh];
   sample_type         wet_ff [IoCh];
   sample_type         dry_ff [IoCh];
   sample_type         res_ff [IoCh];
   sample_type         res_in [IoCh];
   sample_type         wet_in [IoCh];
   sample_type         dry_in [IoCh];
   logic [RampW-1:0]   total_ff, total_in;
   logic [RampW-1:0]   remain_ff, remain_in, remain_new;
   logic               prior_ff, prior_in;
   logic               started_ff, started_in;
   logic               from_dry_ff, from_dry_in;
   logic               proc_ff, eob_ff, fading_ff, fading_in;
   logic [LaneW-1:0]   lane_ff, lane_in;
   logic               accept;
   logic               out_free;
   logic               rsp_valid_ff;
   sample_type         out_ff [IoCh];
   logic               out_fading_ff;
   div_req_type        div_req;
   div_rsp_type        div_rsp;
   lerp_req_type       lerp_req;
   lerp_rsp_type       lerp_rsp;

   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      wet_in[0] = req_tdata[SampleW-1:0];
      wet_in[1] = req_tdata[2*SampleW-1:SampleW];
      dry_in[0] = req_tdata[3*SampleW-1:2*SampleW];
      dry_in[1] = req_tdata[4*SampleW-1:3*SampleW];
      total_in = total_ff;
      remain_new = remain_ff;
      prior_in = prior_ff;
      started_in = started_ff;
      from_dry_in = from_dry_ff;
      for (int c = 0; c < IoCh; c++) begin
         start_in[c] = start_ff[c];
         res_in[c] = (c < NumLanes) ? (req_tuser ? wet_in[c] : dry_in[c]) : '0;
      end
      if (!started_ff) begin
         started_in = 1'b1;
         prior_in = req_tuser;
      end else if (req_tuser != prior_ff) begin
         total_in = (ramp_ff == '0) ? RampW'(1) : ramp_ff;
         remain_new = total_in;
         for (int c = 0; c < IoCh; c++) begin
            start_in[c] = held_ff[c];
         end
         from_dry_in = req_tuser && (remain_ff == '0);
         prior_in = req_tuser;
      end
      fading_in = remain_new != '0;
      remain_in = fading_in ? remain_new - 1'b1 : remain_new;
      div_req.start = accept && fading_in;
      div_req.total = total_in;
      div_req.completed = total_in - remain_new + 1'b1;
   end

   always_comb begin
      lerp_req.go = (state_ff == ST_ISSUE);
      lerp_req.src = from_dry_ff ? dry_ff[lane_ff] : start_ff[lane_ff];
      lerp_req.dst = proc_ff ? wet_ff[lane_ff] : dry_ff[lane_ff];
      lerp_req.mix = div_rsp.mix;
   end

   always_comb begin
      state_in = state_ff;
      lane_in = lane_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = fading_in ? ST_DIV : ST_FINISH;
               lane_in = '0;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (lerp_rsp.valid) begin
               if (lane_ff == LastLane) begin
                  state_in = ST_FINISH;
               end else begin
                  lane_in = lane_ff + 1'b1;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lane_ff <= '0;
         ramp_ff <= RampReset;
         total_ff <= '0;
         remain_ff <= '0;
         prior_ff <= 1'b0;
         started_ff <= 1'b0;
         from_dry_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < IoCh; c++) begin
            start_ff[c] <= '0;
            held_ff[c] <= '0;
         end
      end else begin
         state_ff <= state_in;
         lane_ff <= lane_in;
         if (csr_wr_en) begin
            ramp_ff <= csr_wr_data;
         end
         if (accept) begin
            total_ff <= total_in;
            remain_ff <= remain_in;
            prior_ff <= prior_in;
            started_ff <= started_in;
            from_dry_ff <= from_dry_in;
            for (int c = 0; c < IoCh; c++) begin
               start_ff[c] <= start_in[c];
            end
         end
         if (state_ff == ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
            if (eob_ff) begin
               for (int c = 0; c < IoCh; c++) begin
                  held_ff[c] <= res_ff[c];
               end
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         proc_ff <= req_tuser;
         eob_ff <= req_tlast;
         fading_ff <= fading_in;
         for (int c = 0; c < IoCh; c++) begin
            wet_ff[c] <= wet_in[c];
            dry_ff[c] <= dry_in[c];
            res_ff[c] <= res_in[c];
         end
      end else if (state_ff == ST_WAIT && lerp_rsp.valid) begin
         res_ff[lane_ff] <= lerp_rsp.result;
      end
      if (state_ff == ST_FINISH && out_free) begin
         out_fading_ff <= fading_ff;
         for (int c = 0; c < IoCh; c++) begin
            out_ff[c] <= res_ff[c];
         end
      end
   end

   bcr_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   bcr_lerp u_lerp (
      .clock (clock),
      .reset (reset),
      .req   (lerp_req),
      .rsp   (lerp_rsp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {out_ff[1], out_ff[0]};
   assign rsp_tuser = out_fading_ff;

endmodule

FILE: rtl/bcr_div.sv
// Serial restoring divider for the Q1.16 crossfade mix fraction.
module bcr_div
   import bcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DivCntW-1:0]   cnt_ff, cnt_in;
   logic [RampW:0]       rem_ff, rem_in;
   logic [RampW-1:0]     dvs_ff, dvs_in;
   logic [MixW-1:0]      quo_ff, quo_in;
   logic [RampW:0]       trial;
   logic                 ge;

   // first step compares completed against total, later steps shift in zeros
   always_comb begin
      trial = (cnt_ff == '0) ? rem_ff : {rem_ff[RampW-1:0], 1'b0};
      ge = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      quo_in = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         rem_in = {1'b0, req.completed};
         dvs_in = req.total;
      end else if (busy_ff) begin
         rem_in = ge ? trial - {1'b0, dvs_ff} : trial;
         quo_in = {quo_ff[MixW-2:0], ge};
         if (cnt_ff == DivCntW'(DivSteps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign rsp.done = done_ff;
   assign rsp.mix = quo_ff;

endmodule

FILE: rtl/bcr_lerp.sv
// Three-stage interpolate unit: difference, multiply by mix, round and saturate.
module bcr_lerp
   import bcr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  lerp_req_type req,
   output lerp_rsp_type rsp
);

   localparam int unsigned DiffW = SampleW + 1;
   localparam int unsigned ProdW = DiffW + MixW + 1;
   localparam int unsigned QW = ProdW - 16;
   localparam int unsigned SumW = QW + 1;

   logic                    v1_ff, v2_ff, v3_ff;
   logic signed [DiffW-1:0] diff_ff, diff_in;
   sample_type              src1_ff, src2_ff;
   logic [MixW-1:0]         mix1_ff;
   logic signed [ProdW-1:0] prod_ff, prod_in;
   logic [ProdW-1:0]        rnd;
   logic [QW-1:0]           quo;
   logic [SumW-1:0]         sum;
   logic                    ovf_hi, ovf_lo;
   sample_type              res_ff, res_in;

   always_comb begin
      diff_in = {req.dst[SampleW-1], req.dst} - {req.src[SampleW-1], req.src};
      prod_in = $signed(diff_ff) * $signed({1'b0, mix1_ff});
      rnd = prod_ff + ProdW'(32768);
      quo = rnd[ProdW-1:16];
      sum = {{(SumW - SampleW){src2_ff[SampleW-1]}}, src2_ff} + {quo[QW-1], quo};
      ovf_hi = !sum[SumW-1] && (sum[SumW-2:SampleW-1] != '0);
      ovf_lo = sum[SumW-1] && (sum[SumW-2:SampleW-1] != '1);
      if (ovf_hi) begin
         res_in = {1'b0, {(SampleW - 1){1'b1}}};
      end else if (ovf_lo) begin
         res_in = {1'b1, {(SampleW - 1){1'b0}}};
      end else begin
         res_in = sum[SampleW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= req.go;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      diff_ff <= diff_in;
      src1_ff <= req.src;
      mix1_ff <= req.mix;
      prod_ff <= prod_in;
      src2_ff <= src1_ff;
      res_ff <= res_in;
   end

   assign rsp.valid = v3_ff;
   assign rsp.result = res_ff;

endmodule

FILE: rtl/bcr_checker.sv
// Port-level checks for the bypass crossfade ramp, bound to the top level.
module bcr_checker
   import bcr_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [2*SampleW-1:0] rsp_tdata,
   input logic                 rsp_tuser
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   // one frame in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready stayed high after accept");

   // a new result is loaded only as the sequencer returns to idle
   a_rsp_rise_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("result appeared while a frame was still in work");

endmodule

bind bypass_crossfade_ramp bcr_checker u_bcr_checker (.*);

FILE: tb/tb_bypass_crossfade_ramp.sv
// Testbench for the bypass crossfade ramp: directed and random frames checked against a predictor.
module tb_bypass_crossfade_ramp;
   import bcr_pkg::*;

   localparam sample_type SampleMax = sample_type'(24'h7FFFFF);
   localparam sample_type SampleMin = sample_type'(24'h800000);
   localparam int WatchdogLimit = 4000;
   localparam int DrainCycles = 40;
   localparam int RandomPhases = 8;
   localparam int FramesPerPhase = 180;

   typedef struct packed {
      logic       fading;
      sample_type right;
      sample_type left;
   } frame_out_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [4*SampleW-1:0] req_tdata = '0;
   logic                 req_tuser = 1'b0;
   logic                 req_tlast = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [2*SampleW-1:0] rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_wr_en = 1'b0;
   logic [RampW-1:0]     csr_wr_data = '0;

   bypass_crossfade_ramp dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #2 clock = ~clock;

   // crossfade state mirror
   logic [RampW-1:0] ramp_len = RampReset;
   sample_type       fade_src [IoCh] = '{default: '0};
   sample_type       held_out [IoCh] = '{default: '0};
   logic [RampW-1:0] fade_len = '0;
   logic [RampW-1:0] fade_left = '0;
   logic             last_proc = 1'b0;
   logic             seen_first = 1'b0;
   logic             src_is_dry = 1'b0;

   frame_out_type expected_frames [$];
   frame_out_type popped_frame;
   int            mismatch_count = 0;
   int            quiet_cycles = 0;
   int            send_idle_pct = 0;
   int            stall_pct = 0;

   function automatic sample_type blend(sample_type src, sample_type dst, longint mix);
      longint acc;
      acc = longint'(src) + (((longint'(dst) - longint'(src)) * mix + 32768) >>> 16);
      if (acc > longint'(SampleMax)) return SampleMax;
      if (acc < longint'(SampleMin)) return SampleMin;
      return sample_type'(acc);
   endfunction

   function automatic frame_out_type crossfade_step(sample_type wet [IoCh],
                                                    sample_type dry [IoCh],
                                                    logic proc, logic eob);
      sample_type    res [IoCh];
      logic          was_fading;
      longint        done_frames;
      longint        mix;
      frame_out_type o;
      if (!seen_first) begin
         seen_first = 1'b1;
         last_proc = proc;
      end else if (proc != last_proc) begin
         was_fading = fade_left != 0;
         fade_len = (ramp_len == 0) ? RampW'(1) : ramp_len;
         fade_left = fade_len;
         fade_src = held_out;
         src_is_dry = proc && !was_fading;
         last_proc = proc;
      end
      o.fading = fade_left != 0;
      if (fade_left != 0) begin
         done_frames = longint'(fade_len) - longint'(fade_left) + 1;
         mix = (done_frames << 16) / longint'(fade_len);
         for (int c = 0; c < IoCh; c++) begin
            res[c] = blend(src_is_dry ? dry[c] : fade_src[c], proc ? wet[c] : dry[c], mix);
         end
         fade_left = fade_left - 1'b1;
      end else begin
         for (int c = 0; c < IoCh; c++) begin
            res[c] = proc ? wet[c] : dry[c];
         end
      end
      if (eob) begin
         held_out = res;
      end
      o.left = res[0];
      o.right = res[1];
      return o;
   endfunction

   function automatic sample_type random_sample();
      case ($urandom_range(15))
         0: return SampleMax;
         1: return SampleMin;
         2: return '0;
         default: return sample_type'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(string what, frame_out_type want, frame_out_type got);
      if (mismatch_count < 10) begin
         $display("mismatch, %s: expected L=%0d R=%0d fading=%0b, got L=%0d R=%0d fading=%0b",
                  what, want.left, want.right, want.fading, got.left, got.right, got.fading);
      end
      mismatch_count++;
   endtask

   // result checker, also drives receiver backpressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_frames.size() == 0) begin
            report_mismatch("word with none expected", '0, {rsp_tuser, rsp_tdata});
         end else begin
            popped_frame = expected_frames.pop_front();
            if (rsp_tdata[SampleW-1:0] !== popped_frame.left ||
                rsp_tdata[2*SampleW-1:SampleW] !== popped_frame.right ||
                rsp_tuser !== popped_frame.fading) begin
               report_mismatch("field differs", popped_frame, {rsp_tuser, rsp_tdata});
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WatchdogLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_frame(input sample_type wl, wr, dl, dr, input logic proc, eob);
      sample_type wet [IoCh];
      sample_type dry [IoCh];
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {dr, dl, wr, wl};
      req_tuser <= proc;
      req_tlast <= eob;
      do @(posedge clock); while (!req_tready);
      wet = '{wl, wr};
      dry = '{dl, dr};
      expected_frames.push_back(crossfade_step(wet, dry, proc, eob));
   endtask

   task automatic send_random(input logic proc, eob);
      send_frame(random_sample(), random_sample(), random_sample(), random_sample(), proc, eob);
   endtask

   // hold off the sender until every expected word is back, then let the block go idle
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_ramp(input logic [RampW-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      ramp_len = value;
   endtask

   // first frame never fades, even though the flag differs from reset
   task automatic test_first_frame();
      send_frame(SampleMax, SampleMin, SampleMin, SampleMax, 1'b1, 1'b1);
      send_frame(SampleMin, SampleMax, SampleMax, SampleMin, 1'b1, 1'b0);
   endtask

   task automatic test_fade_from_held();
      for (int i = 0; i < 5; i++) begin
         send_frame(random_sample(), random_sample(), SampleMin, SampleMax, 1'b0, i == 1);
      end
   endtask

   task automatic test_fresh_switch_from_dry();
      for (int i = 0; i < 2; i++) begin
         send_random(1'b1, 1'b1);
      end
   endtask

   task automatic test_change_mid_fade();
      send_random(1'b0, 1'b0);
      for (int i = 0; i < 5; i++) begin
         send_random(1'b1, i == 2);
      end
   endtask

   task automatic test_zero_ramp();
      settle();
      write_ramp('0);
      send_random(1'b1, 1'b1);
      send_random(1'b0, 1'b0);
      send_random(1'b0, 1'b1);
      send_random(1'b1, 1'b0);
   endtask

   task automatic test_longest_ramp();
      settle();
      write_ramp('1);
      send_random(1'b0, 1'b1);
      send_random(1'b0, 1'b0);
      send_random(1'b1, 1'b0);
      send_random(1'b1, 1'b1);
   endtask

   task automatic test_random_traffic();
      logic [RampW-1:0] ramps [RandomPhases];
      logic             proc;
      int               mode;
      ramps = '{16'd2, 16'd16, RampReset, 16'd1, 16'hFFFF, 16'd7, 16'd0, 16'd3};
      ramps[RandomPhases-1] = RampW'($urandom_range(64, 1));
      proc = 1'b0;
      for (int phase = 0; phase < RandomPhases; phase++) begin
         settle();
         write_ramp(ramps[phase]);
         mode = phase % 4;
         send_idle_pct = (mode == 1) ? 50 : (mode == 3) ? 18 : 0;
         stall_pct = (mode == 2) ? 50 : (mode == 3) ? 18 : 0;
         for (int i = 0; i < FramesPerPhase; i++) begin
            if ($urandom_range((ramps[phase] <= 16) ? 3 : 15) == 0) begin
               proc = ~proc;
            end
            send_random(proc, $urandom_range(3) == 0);
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      write_ramp(16'd4);
      test_first_frame();
      test_fade_from_held();
      test_fresh_switch_from_dry();
      test_change_mid_fade();
      test_zero_ramp();
      test_longest_ramp();
      test_random_traffic();
      settle();
      if (mismatch_count == 0 && expected_frames.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
